@@ rtl/tpsd_pkg.sv @@
// Shared types and constants for the texel and palette stream decoder.
// Used by the decode stage, the result buffer and the top level.
// Depends on nothing.
package tpsd_pkg;

  // Configuration port geometry.
  localparam int unsigned CFG_INDEX_W = 3;
  localparam int unsigned CFG_DATA_W  = 16;

  // Register indexes on the configuration port.
  localparam logic [CFG_INDEX_W-1:0] REG_PIXEL_FORMAT   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PALETTE_FORMAT = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STORAGE_MODE   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_COLOR_COUNT    = 3'd4;

  // Pixel format codes.
  localparam logic [2:0] PIX_RGBA16 = 3'd1;
  localparam logic [2:0] PIX_RGB24  = 3'd2;
  localparam logic [2:0] PIX_RGBA32 = 3'd3;
  localparam logic [2:0] PIX_IDX4   = 3'd4;
  localparam logic [2:0] PIX_IDX8   = 3'd5;

  // Palette format codes.
  localparam logic [1:0] PAL_NONE   = 2'd0;
  localparam logic [1:0] PAL_RGBA16 = 2'd1;
  localparam logic [1:0] PAL_RGB24  = 2'd2;
  localparam logic [1:0] PAL_RGBA32 = 2'd3;

  // Color word sizes as the index of their last byte.
  localparam logic [1:0] WORD_RGBA16 = 2'd1;
  localparam logic [1:0] WORD_RGBA32 = 2'd3;

  // Result kinds.
  typedef enum logic [1:0] {
    KIND_INDEX = 2'd0,
    KIND_COLOR = 2'd1,
    KIND_ENTRY = 2'd2,
    KIND_ERROR = 2'd3
  } kind_t;

  typedef struct packed {
    logic [2:0]  pixel_format;
    logic [1:0]  palette_format;
    logic        palette_storage_mode;
    logic [15:0] image_width;
    logic [8:0]  color_count;
  } cfg_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] position;
    logic [7:0]  pixel_index;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        row_end;
    logic        last;
  } result_t;

  // What one request produces: zero, one or two results.
  typedef struct packed {
    logic [1:0] count;
    result_t    first;
    result_t    second;
  } dec_out_t;

endpackage

@@ rtl/tpsd_if.sv @@
// Valid/ready channel interfaces for the texel and palette stream decoder.
// The input channel carries tagged bytes, the output channel carries decoded results.
// Depends on nothing.
interface tpsd_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] data_byte;

  modport source (output valid, command, data_byte, input ready);
  modport sink (input valid, command, data_byte, output ready);
endinterface

interface tpsd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] position;
  logic [7:0]  pixel_index;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic        row_end;
  logic        last;

  modport source (output valid, kind, position, pixel_index, red, green, blue, alpha,
                  row_end, last, input ready);
  modport sink (input valid, kind, position, pixel_index, red, green, blue, alpha,
                row_end, last, output ready);
endinterface

@@ rtl/tpsd_decode.sv @@
// Decode stage: byte gathering, color widening, column and palette slot counting.
// Holds the stream state and turns one accepted byte into up to two results.
// Depends on tpsd_pkg.
module tpsd_decode #(
  parameter int unsigned MAX_COLORS = 256
) (
  input  logic              clk,
  input  logic              rst_n,
  input  tpsd_pkg::cfg_t    cfg,
  input  logic              accept,
  input  logic              command,
  input  logic [7:0]        data_byte,
  output tpsd_pkg::dec_out_t dec
);
  import tpsd_pkg::*;

  localparam int unsigned ENTRY_W = $clog2(MAX_COLORS + 1);
  localparam logic [8:0]  MAX_CC  = 9'(MAX_COLORS);

  typedef struct packed {
    logic        done;
    logic [31:0] word;
    logic [23:0] gather;
    logic [1:0]  phase;
  } gather_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } color_t;

  // Adds one byte to the shared gather register at the given phase.
  function automatic gather_t do_gather(logic [1:0] p, logic [1:0] fmt, logic [7:0] b,
                                        logic [23:0] g);
    gather_t r;
    r.done   = (p >= fmt);
    r.gather = g;
    r.phase  = r.done ? 2'd0 : p + 2'd1;
    case (p)
      2'd0: r.word = {24'd0, b};
      2'd1: r.word = {16'd0, b, g[7:0]};
      2'd2: r.word = {8'd0, b, g[15:0]};
      default: r.word = {b, g};
    endcase
    if (!r.done) begin
      case (p)
        2'd0: r.gather = {g[23:8], b};
        2'd1: r.gather = {g[23:16], b, g[7:0]};
        default: r.gather = {b, g[15:0]};
      endcase
    end
    return r;
  endfunction

  // Widens a gathered word to 8-bit channels.
  function automatic color_t do_color(logic [31:0] w, logic [1:0] fmt);
    color_t c;
    if (fmt == WORD_RGBA16) begin
      c.red   = {w[4:0], 3'b000};
      c.green = {w[9:5], 3'b000};
      c.blue  = {w[14:10], 3'b000};
      c.alpha = w[15] ? 8'hFF : 8'h00;
    end else begin
      c.red   = w[7:0];
      c.green = w[15:8];
      c.blue  = w[23:16];
      if (fmt == WORD_RGBA32) begin
        c.alpha = w[31] ? 8'hFF : {w[30:24], 1'b0};
      end else begin
        c.alpha = 8'hFF;
      end
    end
    return c;
  endfunction

  logic [23:0]        gather_r, gather_nxt;
  logic [1:0]         pix_phase_r, pix_phase_nxt;
  logic [1:0]         ent_phase_r, ent_phase_nxt;
  logic [15:0]        column_r, column_nxt;
  logic [ENTRY_W-1:0] entry_r, entry_nxt;

  logic [8:0]  ncol;
  logic [8:0]  slot;
  logic [16:0] sum0, sum1;
  logic        re0, re1;
  logic        is_index, is_direct;
  gather_t     g_pal, g_pix;
  color_t      col_pal, col_pix;

  // Column arithmetic for the current and the following pixel.
  assign sum0 = {1'b0, column_r} + 17'd1;
  assign re0  = sum0 >= {1'b0, cfg.image_width};
  assign sum1 = {1'b0, sum0[15:0]} + 17'd1;
  assign re1  = sum1 >= {1'b0, cfg.image_width};

  // Palette entry count is limited by the palette capacity.
  assign ncol = (cfg.color_count > MAX_CC) ? MAX_CC : cfg.color_count;

  assign is_index  = (cfg.pixel_format == PIX_IDX4) || (cfg.pixel_format == PIX_IDX8);
  assign is_direct = (cfg.pixel_format == PIX_RGBA16) || (cfg.pixel_format == PIX_RGB24) ||
                     (cfg.pixel_format == PIX_RGBA32);

  assign g_pal   = do_gather(ent_phase_r, cfg.palette_format, data_byte, gather_r);
  assign g_pix   = do_gather(pix_phase_r, cfg.pixel_format[1:0], data_byte, gather_r);
  assign col_pal = do_color(g_pal.word, cfg.palette_format);
  assign col_pix = do_color(g_pix.word, cfg.pixel_format[1:0]);

  // Slot reorder: with storage mode 0, bits 3 and 4 swap inside every whole 32-entry page.
  always_comb begin
    slot = 9'(entry_r);
    if (!cfg.palette_storage_mode && (slot[8:5] < ncol[8:5])) begin
      slot = {slot[8:5], slot[3], slot[4], slot[2:0]};
    end
  end

  // Result selection and next state.
  always_comb begin
    gather_nxt    = gather_r;
    pix_phase_nxt = pix_phase_r;
    ent_phase_nxt = ent_phase_r;
    column_nxt    = column_r;
    entry_nxt     = entry_r;
    dec           = '0;
    if (command) begin
      if ((cfg.palette_format != PAL_NONE) && (9'(entry_r) < ncol)) begin
        gather_nxt    = g_pal.gather;
        ent_phase_nxt = g_pal.phase;
        if (g_pal.done) begin
          entry_nxt           = entry_r + ENTRY_W'(1);
          dec.count           = 2'd1;
          dec.first.kind      = KIND_ENTRY;
          dec.first.position  = 16'(slot);
          dec.first.red       = col_pal.red;
          dec.first.green     = col_pal.green;
          dec.first.blue      = col_pal.blue;
          dec.first.alpha     = col_pal.alpha;
          dec.first.last      = 1'b1;
        end
      end
    end else if (is_index && (cfg.palette_format != PAL_NONE)) begin
      dec.count           = 2'd1;
      dec.first.kind      = KIND_INDEX;
      dec.first.position  = column_r;
      dec.first.row_end   = re0;
      dec.first.last      = 1'b1;
      column_nxt          = re0 ? 16'd0 : sum0[15:0];
      if (cfg.pixel_format == PIX_IDX8) begin
        dec.first.pixel_index = data_byte;
      end else begin
        dec.first.pixel_index = {4'd0, data_byte[3:0]};
        if (!re0) begin
          // Both nibbles fit in this row: the high nibble follows.
          dec.count              = 2'd2;
          dec.first.last         = 1'b0;
          dec.second.kind        = KIND_INDEX;
          dec.second.position    = sum0[15:0];
          dec.second.pixel_index = {4'd0, data_byte[7:4]};
          dec.second.row_end     = re1;
          dec.second.last        = 1'b1;
          column_nxt             = re1 ? 16'd0 : sum1[15:0];
        end
      end
    end else if (is_direct && (cfg.palette_format == PAL_NONE)) begin
      gather_nxt    = g_pix.gather;
      pix_phase_nxt = g_pix.phase;
      if (g_pix.done) begin
        dec.count          = 2'd1;
        dec.first.kind     = KIND_COLOR;
        dec.first.position = column_r;
        dec.first.red      = col_pix.red;
        dec.first.green    = col_pix.green;
        dec.first.blue     = col_pix.blue;
        dec.first.alpha    = col_pix.alpha;
        dec.first.row_end  = re0;
        dec.first.last     = 1'b1;
        column_nxt         = re0 ? 16'd0 : sum0[15:0];
      end
    end else begin
      dec.count      = 2'd1;
      dec.first.kind = KIND_ERROR;
      dec.first.last = 1'b1;
    end
  end

  // Stream state advances only on an accepted request.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gather_r    <= '0;
      pix_phase_r <= '0;
      ent_phase_r <= '0;
      column_r    <= '0;
      entry_r     <= '0;
    end else if (accept) begin
      gather_r    <= gather_nxt;
      pix_phase_r <= pix_phase_nxt;
      ent_phase_r <= ent_phase_nxt;
      column_r    <= column_nxt;
      entry_r     <= entry_nxt;
    end
  end

endmodule

@@ rtl/tpsd_out_buf.sv @@
// Result register pair: holds the up to two results of one request and
// presents them on the output channel one per cycle while out_stream is ready.
// Depends on tpsd_pkg and tpsd_out_if.
module tpsd_out_buf (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               load,
  input  tpsd_pkg::dec_out_t dec,
  output logic               can_load,
  output logic [1:0]         fill,
  tpsd_out_if.source         out_stream
);
  import tpsd_pkg::*;

  result_t    head_r, head_nxt;
  result_t    tail_r, tail_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       pop;

  assign pop      = out_stream.valid && out_stream.ready;
  // A new request may enter when the buffer is empty or empties this cycle.
  assign can_load = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_stream.ready);
  assign fill     = cnt_r;

  // Load the pair on a request with results, else shift on a pop.
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    cnt_nxt  = cnt_r;
    if (load && (dec.count != 2'd0)) begin
      head_nxt = dec.first;
      tail_nxt = dec.second;
      cnt_nxt  = dec.count;
    end else if (pop) begin
      head_nxt = tail_r;
      cnt_nxt  = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    tail_r <= tail_nxt;
  end

  assign out_stream.valid       = (cnt_r != 2'd0);
  assign out_stream.kind        = head_r.kind;
  assign out_stream.position    = head_r.position;
  assign out_stream.pixel_index = head_r.pixel_index;
  assign out_stream.red         = head_r.red;
  assign out_stream.green       = head_r.green;
  assign out_stream.blue        = head_r.blue;
  assign out_stream.alpha       = head_r.alpha;
  assign out_stream.row_end     = head_r.row_end;
  assign out_stream.last        = head_r.last;

endmodule

@@ rtl/texel_palette_stream_decoder_core.sv @@
// Top level of the texel and palette stream decoder: configuration registers,
// decode stage and result register pair. Depends on tpsd_pkg, tpsd_if,
// tpsd_decode and tpsd_out_buf.
//
//   Channel      Direction  Moves
//   in_stream    sink       command, data_byte (one tagged byte per request)
//   out_stream   source     kind, position, pixel_index, red, green, blue, alpha,
//                           row_end, last
//   cfg_*        input      plain register write, no read-back
//
// A byte is decoded in the cycle it is accepted and its results sit in the
// result registers from the next cycle. One byte per cycle is sustained while
// out_stream is ready; a 4-bit index byte whose low nibble does not end its
// row gives two results, and no byte is taken while both are held. Reset is
// synchronous and clears the stream state and loads the register defaults.
// The input stalls only while the result registers cannot drain in the same cycle.
module texel_palette_stream_decoder_core #(
  parameter int unsigned MAX_COLORS = 256
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_wr_en,
  input  logic [tpsd_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tpsd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  tpsd_in_if.sink                              in_stream,
  tpsd_out_if.source                           out_stream
);
  import tpsd_pkg::*;

  cfg_t     cfg_r;
  dec_out_t dec;
  logic     accept;
  logic     can_load;
  logic [1:0] fill;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pixel_format         <= PIX_IDX8;
      cfg_r.palette_format       <= PAL_RGBA32;
      cfg_r.palette_storage_mode <= 1'b0;
      cfg_r.image_width          <= 16'd1;
      cfg_r.color_count          <= 9'd256;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_PIXEL_FORMAT:   cfg_r.pixel_format         <= cfg_wdata[2:0];
        REG_PALETTE_FORMAT: cfg_r.palette_format       <= cfg_wdata[1:0];
        REG_STORAGE_MODE:   cfg_r.palette_storage_mode <= cfg_wdata[0];
        REG_IMAGE_WIDTH:    cfg_r.image_width          <= cfg_wdata;
        REG_COLOR_COUNT:    cfg_r.color_count          <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  assign in_stream.ready = can_load;
  assign accept          = in_stream.valid && can_load;

  tpsd_decode #(
    .MAX_COLORS (MAX_COLORS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .accept    (accept),
    .command   (in_stream.command),
    .data_byte (in_stream.data_byte),
    .dec       (dec)
  );

  tpsd_out_buf u_out_buf (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (accept),
    .dec        (dec),
    .can_load   (can_load),
    .fill       (fill),
    .out_stream (out_stream)
  );

  // A result that is not the last of its request always has its partner queued.
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_stream.valid && !out_stream.last) |-> (fill == 2'd2))
    else $error("non-final result shown without its partner");

  // A request is never taken while both result registers are full.
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (fill != 2'd2))
    else $error("request accepted with full result registers");

  // A request that produces results shows them in the next cycle.
  assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (dec.count != 2'd0)) |=> out_stream.valid)
    else $error("results of an accepted request not presented");

endmodule
